// ===== design/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORD_LOG  = 5;
    localparam int ORD_W     = 5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_TOOBIG   = 2'd2,
        ST_NOTALLOC = 2'd3
    } status_t;

endpackage

// ===== design/bba_ram.sv =====
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/buddy_block_allocator_unit.sv =====
`timescale 1ns / 1ps

// Buddy allocator over a heap of 2^HEAP_BITS bytes with NUM_ORDERS power-of-two block
// sizes starting at 2^MIN_ORDER bytes. Free bits sit in a 32-bit-wide word memory and
// allocation orders in a per-leaf memory, both read-modify-written by one sequencer,
// so one transaction is handled at a time. After reset a clearing pass over all
// 2^(HEAP_BITS-MIN_ORDER) leaf entries (4096 by default) runs before the first transaction
// is taken. An allocate scans the free-bit memory one word per read (up to about
// 2^(HEAP_BITS-MIN_ORDER-4) words plus one per small order, 259 by default), then splits
// the found block level by level down to the requested order; a free clears the leaf's
// order entry and merges the block with free buddies level by level.

module buddy_block_allocator_unit #(
    parameter int HEAP_BITS    = 16,
    parameter int MIN_ORDER    = 4,
    parameter int NUM_ORDERS   = 12,
    parameter int HEADER_BYTES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [15:0] request_bytes,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] address,
    output logic [1:0]  status
);

    localparam int WB        = bba_pkg::WORD_BITS;
    localparam int WBL       = bba_pkg::WORD_LOG;
    localparam int LEAVES    = 1 << (HEAP_BITS - MIN_ORDER);
    localparam int FREE_BITS = 2 * LEAVES;
    localparam int GW        = $clog2(FREE_BITS) + 1;
    localparam int WORDS     = (FREE_BITS + WB - 1) / WB;
    localparam int FWA       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAW       = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int OW        = $clog2(NUM_ORDERS + 1);
    localparam int PW        = FWA + WBL;
    localparam int XW        = ((PW > GW) ? PW : GW) + 1;
    localparam int RW        = 17;
    localparam int TOP_SIZE  = 1 << (MIN_ORDER + NUM_ORDERS - 1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_WT,
        S_SPLIT,
        S_BOP_RD,
        S_BOP_WT,
        S_MARK,
        S_FA_WT,
        S_MRG_RD,
        S_MRG_WT,
        S_DONE
    } state_t;

    function automatic logic [GW-1:0] blocks_of(input logic [OW-1:0] k);
        return GW'(LEAVES) >> k;
    endfunction

    function automatic logic [GW-1:0] base_of(input logic [OW-1:0] k);
        return GW'(FREE_BITS) - (blocks_of(k) << 1);
    endfunction

    function automatic logic [FWA-1:0] word_of(input logic [GW-1:0] g);
        return FWA'(g >> WBL);
    endfunction

    function automatic logic [WBL-1:0] bit_of(input logic [GW-1:0] g);
        return WBL'(g);
    endfunction

    function automatic logic [WB-1:0] init_word(input logic [FWA-1:0] w);
        logic [WB-1:0] v;
        logic [GW-1:0] g;
        v = '0;
        for (int kk = 0; kk < NUM_ORDERS; kk++)
        begin
            g = base_of(OW'(kk)) + GW'(1);
            if (blocks_of(OW'(kk)) > GW'(1) && word_of(g) == w)
            begin
                v[bit_of(g)] = 1'b1;
            end
        end
        return v;
    endfunction

    state_t                      state_reg, state_next;
    state_t                      ret_reg, ret_next;
    logic [LAW-1:0]              clr_reg, clr_next;
    logic [OW-1:0]               ord_reg, ord_next;
    logic [OW-1:0]               cur_reg, cur_next;
    logic [FWA-1:0]              scan_w_reg, scan_w_next;
    logic [GW-1:0]               idx_reg, idx_next;
    logic [LAW-1:0]              leaf_reg, leaf_next;
    logic [GW-1:0]               bop_g_reg, bop_g_next;
    logic                        bop_v_reg, bop_v_next;
    logic [15:0]                 res_addr_reg, res_addr_next;
    bba_pkg::status_t            res_st_reg, res_st_next;
    logic                        out_valid_reg, out_valid_next;
    logic [15:0]                 out_addr_reg, out_addr_next;
    logic [1:0]                  out_st_reg, out_st_next;

    logic                        fm_we;
    logic [FWA-1:0]              fm_waddr, fm_raddr;
    logic [WB-1:0]               fm_wdata, fm_rdata;
    logic                        ao_we;
    logic [LAW-1:0]              ao_waddr, ao_raddr;
    logic [bba_pkg::ORD_W-1:0]   ao_wdata, ao_rdata;

    bba_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_free_mem (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    bba_ram #(.WIDTH(bba_pkg::ORD_W), .DEPTH(LEAVES)) u_order_mem (
        .clk   (clk),
        .we    (ao_we),
        .waddr (ao_waddr),
        .wdata (ao_wdata),
        .raddr (ao_raddr),
        .rdata (ao_rdata)
    );

    logic [RW-1:0]         req;
    logic [OW-1:0]         need_k;
    logic [GW-1:0]         cur_lo, cur_n;
    logic [XW-1:0]         cur_lo_x, cur_hi_x, wpos, pos;
    logic [WB-1:0]         scan_mask, scan_hit;
    logic [WBL-1:0]        first;
    logic [GW-1:0]         hit_g;
    logic [GW-1:0]         buddy_g;
    logic [LAW+MIN_ORDER-1:0] full_addr;
    logic [LAW-1:0]        mark_leaf;
    logic [OW-1:0]         fa_k;
    logic                  out_load;

    always_comb
    begin
        req    = RW'(request_bytes) + RW'(HEADER_BYTES);
        need_k = OW'(NUM_ORDERS - 1);
        for (int kk = NUM_ORDERS - 1; kk >= 0; kk--)
        begin
            if (32'(req) <= (32'd1 << (MIN_ORDER + kk)))
            begin
                need_k = OW'(kk);
            end
        end

        cur_lo   = base_of(cur_reg);
        cur_n    = blocks_of(cur_reg);
        cur_lo_x = XW'(cur_lo);
        cur_hi_x = XW'(cur_lo) + XW'(cur_n);
        wpos     = XW'({scan_w_reg, WBL'(0)});
        for (int b = 0; b < WB; b++)
        begin
            pos          = wpos + XW'(b);
            scan_mask[b] = (pos >= cur_lo_x) && (pos < cur_hi_x);
        end
        scan_hit = fm_rdata & scan_mask;
        first    = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (scan_hit[b])
            begin
                first = WBL'(b);
            end
        end
        hit_g = GW'(wpos + XW'(first));

        buddy_g   = cur_lo + (idx_reg ^ GW'(1));
        mark_leaf = LAW'(idx_reg) << ord_reg;
        full_addr = {mark_leaf, {MIN_ORDER{1'b0}}};
        fa_k      = OW'(ao_rdata - bba_pkg::ORD_W'(1));
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_next       = clr_reg;
        ord_next       = ord_reg;
        cur_next       = cur_reg;
        scan_w_next    = scan_w_reg;
        idx_next       = idx_reg;
        leaf_next      = leaf_reg;
        bop_g_next     = bop_g_reg;
        bop_v_next     = bop_v_reg;
        res_addr_next  = res_addr_reg;
        res_st_next    = res_st_reg;

        fm_we    = 1'b0;
        fm_waddr = scan_w_reg;
        fm_wdata = fm_rdata;
        fm_raddr = scan_w_reg;
        ao_we    = 1'b0;
        ao_waddr = leaf_reg;
        ao_wdata = '0;
        ao_raddr = LAW'(block_address >> MIN_ORDER);

        out_load = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                ao_we    = 1'b1;
                ao_waddr = clr_reg;
                if (32'(clr_reg) < WORDS)
                begin
                    fm_we    = 1'b1;
                    fm_waddr = FWA'(clr_reg);
                    fm_wdata = init_word(FWA'(clr_reg));
                end
                if (32'(clr_reg) == LEAVES - 1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + LAW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next = '0;
                    if (command == bba_pkg::CMD_ALLOC)
                    begin
                        if (32'(req) > TOP_SIZE)
                        begin
                            res_st_next = bba_pkg::ST_TOOBIG;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ord_next    = need_k;
                            cur_next    = need_k;
                            scan_w_next = word_of(base_of(need_k));
                            state_next  = S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        leaf_next = LAW'(block_address >> MIN_ORDER);
                        if (block_address[MIN_ORDER-1:0] != '0
                            || 32'(block_address >> MIN_ORDER) >= LEAVES)
                        begin
                            res_st_next = bba_pkg::ST_NOTALLOC;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FA_WT;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (32'(cur_reg) == NUM_ORDERS)
                begin
                    res_st_next = bba_pkg::ST_NOMEM;
                    state_next  = S_DONE;
                end
                else if (cur_n == '0)
                begin
                    cur_next    = cur_reg + OW'(1);
                    scan_w_next = word_of(base_of(cur_reg + OW'(1)));
                end
                else
                begin
                    state_next = S_SCAN_WT;
                end
            end
            S_SCAN_WT:
            begin
                if (scan_hit != '0)
                begin
                    idx_next   = hit_g - cur_lo;
                    bop_g_next = hit_g;
                    bop_v_next = 1'b0;
                    ret_next   = S_SPLIT;
                    state_next = S_BOP_RD;
                end
                else if (scan_w_reg == word_of(GW'(cur_hi_x - XW'(1))))
                begin
                    cur_next    = cur_reg + OW'(1);
                    scan_w_next = word_of(base_of(cur_reg + OW'(1)));
                    state_next  = S_SCAN_RD;
                end
                else
                begin
                    scan_w_next = scan_w_reg + FWA'(1);
                    state_next  = S_SCAN_RD;
                end
            end
            S_SPLIT:
            begin
                if (cur_reg > ord_reg)
                begin
                    cur_next   = cur_reg - OW'(1);
                    idx_next   = idx_reg << 1;
                    bop_g_next = base_of(cur_reg - OW'(1)) + (idx_reg << 1) + GW'(1);
                    bop_v_next = 1'b1;
                    ret_next   = S_SPLIT;
                    state_next = S_BOP_RD;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_BOP_RD:
            begin
                fm_raddr   = word_of(bop_g_reg);
                state_next = S_BOP_WT;
            end
            S_BOP_WT:
            begin
                fm_we                      = 1'b1;
                fm_waddr                   = word_of(bop_g_reg);
                fm_wdata[bit_of(bop_g_reg)] = bop_v_reg;
                state_next                 = ret_reg;
            end
            S_MARK:
            begin
                ao_we         = 1'b1;
                ao_waddr      = mark_leaf;
                ao_wdata      = bba_pkg::ORD_W'(ord_reg) + bba_pkg::ORD_W'(1);
                res_addr_next = 16'(full_addr);
                res_st_next   = bba_pkg::ST_OK;
                state_next    = S_DONE;
            end
            S_FA_WT:
            begin
                if (ao_rdata == '0)
                begin
                    res_st_next = bba_pkg::ST_NOTALLOC;
                    state_next  = S_DONE;
                end
                else
                begin
                    ao_we      = 1'b1;
                    ao_waddr   = leaf_reg;
                    ao_wdata   = '0;
                    cur_next   = fa_k;
                    idx_next   = GW'(leaf_reg) >> fa_k;
                    state_next = S_MRG_RD;
                end
            end
            S_MRG_RD:
            begin
                fm_raddr = word_of(buddy_g);
                if (32'(cur_reg) + 1 < NUM_ORDERS && (idx_reg ^ GW'(1)) < cur_n)
                begin
                    state_next = S_MRG_WT;
                end
                else
                begin
                    bop_g_next  = cur_lo + idx_reg;
                    bop_v_next  = 1'b1;
                    res_st_next = bba_pkg::ST_OK;
                    ret_next    = S_DONE;
                    state_next  = S_BOP_RD;
                end
            end
            S_MRG_WT:
            begin
                if (fm_rdata[bit_of(buddy_g)])
                begin
                    fm_we                    = 1'b1;
                    fm_waddr                 = word_of(buddy_g);
                    fm_wdata[bit_of(buddy_g)] = 1'b0;
                    idx_next                 = idx_reg >> 1;
                    cur_next                 = cur_reg + OW'(1);
                    state_next               = S_MRG_RD;
                end
                else
                begin
                    bop_g_next  = cur_lo + idx_reg;
                    bop_v_next  = 1'b1;
                    res_st_next = bba_pkg::ST_OK;
                    ret_next    = S_DONE;
                    state_next  = S_BOP_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_st_next    = out_st_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = res_addr_reg;
            out_st_next    = res_st_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            ret_reg       <= S_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg      <= ord_next;
        cur_reg      <= cur_next;
        scan_w_reg   <= scan_w_next;
        idx_reg      <= idx_next;
        leaf_reg     <= leaf_next;
        bop_g_reg    <= bop_g_next;
        bop_v_reg    <= bop_v_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        out_addr_reg <= out_addr_next;
        out_st_reg   <= out_st_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign address   = out_addr_reg;
    assign status    = out_st_reg;

endmodule
